// ----- hdl/iqnco_pkg.sv -----
// Shared types and constants for the I/Q NCO frequency shifter.
// No dependencies; used by the core, its cosine/sine ROM and the checker.
`timescale 1ns / 1ps

package iqnco_pkg;

  // Sample format: offset binary, 128 is zero
  localparam int SAMPLE_BITS = 8;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index, taken from paddr[2] (word address)
  localparam logic REG_PHASE_STEP = 1'b0;

  // pi/2 in Q30, seed of the Taylor series that builds the ROM
  localparam longint PI_HALF_Q30 = 64'sd1686629713;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [APB_ADDR_W-1:0]  apb_addr_t;
  typedef logic [APB_DATA_W-1:0]  apb_data_t;

endpackage

// ----- hdl/iqnco_rom.sv -----
// Cosine/sine lookup ROM with registered read data.
// Contents are built at elaboration from a Q30 Taylor series; uses iqnco_pkg.
`timescale 1ns / 1ps

module iqnco_rom #(
  parameter int TABLE_BITS = 10,
  parameter int COEF_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [TABLE_BITS-1:0]       addr_i,
  output logic signed [COEF_BITS-1:0] cos_o,
  output logic signed [COEF_BITS-1:0] sin_o
);
  import iqnco_pkg::*;

  localparam int     ROM_SIZE = 1 << TABLE_BITS;
  localparam int     QUARTER  = 1 << (TABLE_BITS - 2);
  localparam longint AMP      = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;

  // A * sin(pi/2 * m / QUARTER), elaboration only
  function automatic longint quarter_sin(input longint m);
    longint x;
    longint term;
    longint sum;
    longint v;
    x    = (m * PI_HALF_Q30) >>> (TABLE_BITS - 2);
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      case (n)
        1:       term = term / 64'sd6;
        2:       term = term / 64'sd20;
        3:       term = term / 64'sd42;
        4:       term = term / 64'sd72;
        5:       term = term / 64'sd110;
        6:       term = term / 64'sd156;
        7:       term = term / 64'sd210;
        8:       term = term / 64'sd272;
        9:       term = term / 64'sd342;
        10:      term = term / 64'sd420;
        11:      term = term / 64'sd506;
        default: term = term / 64'sd600;
      endcase
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    v = (sum * AMP + (64'sd1 <<< 29)) >>> 30;
    if (v > AMP) begin
      v = AMP;
    end
    return v;
  endfunction

  logic signed [COEF_BITS-1:0] cos_tab [ROM_SIZE];
  logic signed [COEF_BITS-1:0] sin_tab [ROM_SIZE];

  // Build one quadrant, fold the others by symmetry
  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_entry
    localparam int     QD   = k >> (TABLE_BITS - 2);
    localparam int     RM   = k & (QUARTER - 1);
    localparam longint SV   = quarter_sin(longint'(RM));
    localparam longint CV   = quarter_sin(longint'(QUARTER - RM));
    localparam longint COSV = (QD == 0) ? CV : (QD == 1) ? -SV : (QD == 2) ? -CV : SV;
    localparam longint SINV = (QD == 0) ? SV : (QD == 1) ? CV : (QD == 2) ? -SV : -CV;
    assign cos_tab[k] = COEF_BITS'(COSV);
    assign sin_tab[k] = COEF_BITS'(SINV);
  end

  logic signed [COEF_BITS-1:0] cos_q;
  logic signed [COEF_BITS-1:0] sin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= cos_tab[addr_i];
      sin_q <= sin_tab[addr_i];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ----- hdl/iq_nco_frequency_shifter_core.sv -----
// Top level of the I/Q NCO frequency shifter: phase accumulator, mixer pipeline
// and configuration register. Uses iqnco_pkg and iqnco_rom.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------
// input     | in        | in_valid_i / in_stall_o   | in_i_i, in_q_i (8b each)
// output    | out       | out_valid_o / out_stall_i | out_i_o, out_q_o (8b each)
// config    | in        | APB, pready tied high     | phase_step at address 0
//
// One item per clock sustained while out_stall_i stays low. out_valid_o rises after the
// accepting edge once the item has passed three registers: ROM read and sample, products, result.
// The only feedback path is the phase accumulator add, one item per cycle while items are accepted.
// Reset clears the phase, the step and all stage valid bits.
// A stalled output holds its item; upstream stages keep filling until all three
// are occupied, and only then does in_stall_o rise.

module iq_nco_frequency_shifter_core #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10,
  parameter int COEF_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  iqnco_pkg::apb_addr_t paddr,
  input  iqnco_pkg::apb_data_t pwdata,
  output iqnco_pkg::apb_data_t prdata,
  output logic                pready,
  // input samples
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iqnco_pkg::sample_t  in_i_i,
  input  iqnco_pkg::sample_t  in_q_i,
  // output samples
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iqnco_pkg::sample_t  out_i_o,
  output iqnco_pkg::sample_t  out_q_o
);
  import iqnco_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR    = COEF_BITS - 1;
  localparam int SH_W   = SUM_W - SHR;

  // Add back the DC level and clamp to the sample range
  function automatic sample_t sat_offset(input logic signed [SH_W-1:0] v);
    logic signed [SH_W:0] r;
    r = SH_W'(v) + (SH_W + 1)'(1 << (SAMPLE_BITS - 1));
    if (r < 0) begin
      return '0;
    end else if (r > (SH_W + 1)'((1 << SAMPLE_BITS) - 1)) begin
      return '1;
    end else begin
      return r[SAMPLE_BITS-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic signed [APB_DATA_W-1:0] step_q, step_d;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_PHASE_STEP);
  assign step_d = cfg_wr ? $signed(pwdata) : step_q;
  assign prdata = (paddr[2] == REG_PHASE_STEP) ? apb_data_t'(step_q) : '0;

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage advances when the next one is empty
  // or advancing itself.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s2_free, s1_free;
  logic s1_adv, s2_adv, in_acc;

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign s2_free   = ~s2_valid_q | out_ready;
  assign s1_free   = ~s1_valid_q | s2_free;
  assign s2_adv    = s2_valid_q & out_ready;
  assign s1_adv    = s1_valid_q & s2_free;
  assign in_acc    = in_valid_i & s1_free;
  assign in_stall_o = ~s1_free;

  assign s1_valid_d  = in_acc | (s1_valid_q & ~s2_free);
  assign s2_valid_d  = s1_adv | (s2_valid_q & ~out_ready);
  assign out_valid_d = s2_adv | (out_valid_q & out_stall_i);

  // ---------------------------------------------------------------------------
  // Phase accumulator: advance once per accepted item, after the ROM lookup
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_q, phase_d;

  assign phase_d = in_acc ? phase_q + PHASE_BITS'(step_q) : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      phase_q     <= phase_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: ROM read and sample register. Flipping the MSB of an offset
  // binary sample gives the same value minus 128 in two's complement.
  // ---------------------------------------------------------------------------
  logic signed [COEF_BITS-1:0]   rom_cos, rom_sin;
  logic signed [SAMPLE_BITS-1:0] xi_q, xq_q, xi_d, xq_d;

  iqnco_rom #(
    .TABLE_BITS (TABLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .addr_i (phase_q[PHASE_BITS-1 -: TABLE_BITS]),
    .cos_o  (rom_cos),
    .sin_o  (rom_sin)
  );

  assign xi_d = $signed({~in_i_i[SAMPLE_BITS-1], in_i_i[SAMPLE_BITS-2:0]});
  assign xq_d = $signed({~in_q_i[SAMPLE_BITS-1], in_q_i[SAMPLE_BITS-2:0]});

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xi_q <= xi_d;
      xq_q <= xq_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four products of the complex multiply
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] ic_q, qs_q, is_q, qc_q;
  logic signed [PROD_W-1:0] ic_d, qs_d, is_d, qc_d;

  assign ic_d = PROD_W'(xi_q) * PROD_W'(rom_cos);
  assign qs_d = PROD_W'(xq_q) * PROD_W'(rom_sin);
  assign is_d = PROD_W'(xi_q) * PROD_W'(rom_sin);
  assign qc_d = PROD_W'(xq_q) * PROD_W'(rom_cos);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ic_q <= ic_d;
      qs_q <= qs_d;
      is_q <= is_d;
      qc_q <= qc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, floor shift, re-center and saturate into the result register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_i, sum_q;
  logic signed [SUM_W-1:0] shr_i, shr_q;
  sample_t                 res_i_q, res_q_q, res_i_d, res_q_d;

  assign sum_i   = SUM_W'(ic_q) - SUM_W'(qs_q);
  assign sum_q   = SUM_W'(is_q) + SUM_W'(qc_q);
  assign shr_i   = sum_i >>> SHR;
  assign shr_q   = sum_q >>> SHR;
  assign res_i_d = sat_offset(shr_i[SH_W-1:0]);
  assign res_q_d = sat_offset(shr_q[SH_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      res_i_q <= res_i_d;
      res_q_q <= res_q_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = res_i_q;
  assign out_q_o     = res_q_q;

endmodule

// ----- hdl/iqnco_checker.sv -----
// Port-level checks for the I/Q NCO frequency shifter core, bound to the top.
// Depends on iqnco_pkg and iq_nco_frequency_shifter_core.
`timescale 1ns / 1ps

module iqnco_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input iqnco_pkg::sample_t   out_i_o,
  input iqnco_pkg::sample_t   out_q_o
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Input backs up only when the output is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // An accepted item reaches the output when out_stall_i stays low meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_i_o) && $stable(out_q_o)))
    else $error("stalled result changed");

endmodule

bind iq_nco_frequency_shifter_core iqnco_checker u_checker (.*);
